### design/line_segment_rect_clipper_defines.svh
// ----------------------------------------------------------------------------
// line_segment_rect_clipper_defines
// assertion macros shared by the clipper fifo and back-end modules
// ----------------------------------------------------------------------------
`ifndef LINE_SEGMENT_RECT_CLIPPER_DEFINES_SVH
`define LINE_SEGMENT_RECT_CLIPPER_DEFINES_SVH

// condition must hold at every clock out of reset
`define LSRC_ASSERT_ALWAYS(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent must hold whenever the antecedent holds
`define LSRC_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// consequent must hold at the clock after the antecedent
`define LSRC_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### design/lsrc_pkg.sv
// ----------------------------------------------------------------------------
// lsrc_pkg
// shared constants and types of the segment clipper
// ----------------------------------------------------------------------------
package lsrc_pkg;

  localparam int COORD_BITS = 12;
  localparam int FRAC_BITS  = 16;
  localparam int D_W        = COORD_BITS + 1;
  localparam int U_W        = FRAC_BITS + 1;
  localparam int R_W        = FRAC_BITS + 2;
  localparam int PROD_W     = U_W + 1 + D_W;
  localparam int ACC_W      = PROD_W + 1;
  localparam int NUM_EDGES  = 4;
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_AW    = 1;
  localparam int CNT_W      = 2;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_X = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_Y = 2'd3;

  typedef logic [COORD_BITS-1:0]   coord_t;
  typedef logic signed [D_W-1:0]   delta_t;

  typedef struct packed {
    logic                 pzero;
    logic                 pneg;
    logic                 qneg;
    logic                 big;
    logic                 eq;
    coord_t               pmag;
    logic [D_W-1:0]       rem;
    logic [FRAC_BITS-1:0] quot;
  } edge_t;

  typedef struct packed {
    coord_t                   x0;
    coord_t                   y0;
    delta_t                   dx;
    delta_t                   dy;
    logic                     rej;
    edge_t [NUM_EDGES-1:0]    edges;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

### design/lsrc_if.sv
// ----------------------------------------------------------------------------
// lsrc_if
// request and result channels of the segment clipper
// ----------------------------------------------------------------------------
interface lsrc_in_if;
  logic                 valid;
  logic                 ready;
  lsrc_pkg::coord_t     start_x;
  lsrc_pkg::coord_t     start_y;
  lsrc_pkg::coord_t     end_x;
  lsrc_pkg::coord_t     end_y;

  modport source (output valid, start_x, start_y, end_x, end_y, input ready);
  modport sink   (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

interface lsrc_out_if;
  logic                 valid;
  logic                 ready;
  logic                 visible;
  lsrc_pkg::coord_t     clipped_start_x;
  lsrc_pkg::coord_t     clipped_start_y;
  lsrc_pkg::coord_t     clipped_end_x;
  lsrc_pkg::coord_t     clipped_end_y;

  modport source (output valid, visible, clipped_start_x, clipped_start_y,
                  clipped_end_x, clipped_end_y, input ready);
  modport sink   (input valid, visible, clipped_start_x, clipped_start_y,
                  clipped_end_x, clipped_end_y, output ready);
endinterface

### design/lsrc_front.sv
// ----------------------------------------------------------------------------
// lsrc_front
// takes a segment request, forms the edge tests for the min_x, max_x, min_y and max_y bounds and classifies them
// ----------------------------------------------------------------------------
module lsrc_front (
  input  logic                 clk,
  input  logic                 rst_n,
  lsrc_in_if.sink              in_ch,
  input  lsrc_pkg::coord_t     min_x,
  input  lsrc_pkg::coord_t     min_y,
  input  lsrc_pkg::coord_t     max_x,
  input  lsrc_pkg::coord_t     max_y,
  input  lsrc_pkg::fifo_stat_t stat,
  output logic                 push,
  output lsrc_pkg::item_t      push_item
);

  logic            fr_vld_r;
  lsrc_pkg::item_t fr_item_r;
  lsrc_pkg::item_t item_nxt;
  logic            take;

  always_comb begin
    lsrc_pkg::delta_t sx, sy, ex, ey, dx, dy;
    lsrc_pkg::delta_t p [lsrc_pkg::NUM_EDGES];
    lsrc_pkg::delta_t q [lsrc_pkg::NUM_EDGES];
    lsrc_pkg::delta_t pa, qa;
    logic             empty_win;
    logic             rej;
    sx = $signed({1'b0, in_ch.start_x});
    sy = $signed({1'b0, in_ch.start_y});
    ex = $signed({1'b0, in_ch.end_x});
    ey = $signed({1'b0, in_ch.end_y});
    dx = ex - sx;
    dy = ey - sy;
    p[0] = -dx;
    p[1] = dx;
    p[2] = -dy;
    p[3] = dy;
    q[0] = sx - $signed({1'b0, min_x});
    q[1] = $signed({1'b0, max_x}) - sx;
    q[2] = sy - $signed({1'b0, min_y});
    q[3] = $signed({1'b0, max_y}) - sy;
    empty_win = (min_x >= max_x) || (min_y >= max_y);
    rej = empty_win;
    item_nxt.x0 = in_ch.start_x;
    item_nxt.y0 = in_ch.start_y;
    item_nxt.dx = dx;
    item_nxt.dy = dy;
    for (int i = 0; i < lsrc_pkg::NUM_EDGES; i++) begin
      pa = p[i][lsrc_pkg::D_W-1] ? -p[i] : p[i];
      qa = q[i][lsrc_pkg::D_W-1] ? -q[i] : q[i];
      item_nxt.edges[i].pzero = (p[i] == '0);
      item_nxt.edges[i].pneg  = p[i][lsrc_pkg::D_W-1];
      item_nxt.edges[i].qneg  = q[i][lsrc_pkg::D_W-1];
      item_nxt.edges[i].pmag  = pa[lsrc_pkg::COORD_BITS-1:0];
      item_nxt.edges[i].big   = (qa > pa);
      item_nxt.edges[i].eq    = (qa == pa);
      item_nxt.edges[i].rem   = (qa >= pa) ? '0 : qa;
      item_nxt.edges[i].quot  = '0;
      if ((p[i] == '0) && q[i][lsrc_pkg::D_W-1]) begin
        rej = 1'b1;
      end
    end
    item_nxt.rej = rej;
  end

  assign push        = fr_vld_r && !stat.full;
  assign push_item   = fr_item_r;
  assign in_ch.ready = !fr_vld_r || !stat.full;
  assign take        = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_vld_r <= 1'b0;
    end else if (take) begin
      fr_vld_r <= 1'b1;
    end else if (push) begin
      fr_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      fr_item_r <= item_nxt;
    end
  end

endmodule

### design/lsrc_fifo.sv
// ----------------------------------------------------------------------------
// lsrc_fifo
// short queue between the classify front and the clip back end
// ----------------------------------------------------------------------------
`include "line_segment_rect_clipper_defines.svh"

module lsrc_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  lsrc_pkg::item_t      push_item,
  input  logic                 pop,
  output lsrc_pkg::item_t      pop_item,
  output lsrc_pkg::fifo_stat_t stat
);

  lsrc_pkg::item_t                 slot_r [lsrc_pkg::FIFO_DEPTH];
  logic [lsrc_pkg::FIFO_AW-1:0]    wr_ptr_r;
  logic [lsrc_pkg::FIFO_AW-1:0]    rd_ptr_r;
  logic [lsrc_pkg::CNT_W-1:0]      cnt_r;

  assign stat.full  = (cnt_r == lsrc_pkg::CNT_W'(lsrc_pkg::FIFO_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign pop_item   = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

  `LSRC_ASSERT_ALWAYS(a_cnt_bound, cnt_r <= lsrc_pkg::CNT_W'(lsrc_pkg::FIFO_DEPTH), "fifo count over depth")
  `LSRC_ASSERT_IMP(a_no_overflow, push, !stat.full || pop, "push into full fifo")
  `LSRC_ASSERT_IMP(a_no_underflow, pop, !stat.empty, "pop from empty fifo")

endmodule

### design/lsrc_back.sv
// ----------------------------------------------------------------------------
// lsrc_back
// pipelined edge divide, limit narrowing, interpolation and result register
// ----------------------------------------------------------------------------
`include "line_segment_rect_clipper_defines.svh"

module lsrc_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  lsrc_pkg::item_t      fifo_item,
  input  lsrc_pkg::fifo_stat_t stat,
  output logic                 pop,
  lsrc_out_if.source           out_ch
);

  localparam int DIV_STAGES = lsrc_pkg::FRAC_BITS;

  typedef struct packed {
    lsrc_pkg::coord_t             x0;
    lsrc_pkg::coord_t             y0;
    lsrc_pkg::delta_t             dx;
    lsrc_pkg::delta_t             dy;
    logic                         vis;
    logic [lsrc_pkg::U_W-1:0]     u1;
    logic [lsrc_pkg::U_W-1:0]     u2;
  } cmb_t;

  typedef struct packed {
    lsrc_pkg::coord_t                  x0;
    lsrc_pkg::coord_t                  y0;
    lsrc_pkg::delta_t                  dx;
    lsrc_pkg::delta_t                  dy;
    logic                              vis;
    logic signed [lsrc_pkg::PROD_W-1:0] psx;
    logic signed [lsrc_pkg::PROD_W-1:0] psy;
    logic signed [lsrc_pkg::PROD_W-1:0] pex;
    logic signed [lsrc_pkg::PROD_W-1:0] pey;
  } mul_t;

  typedef struct packed {
    logic             vis;
    lsrc_pkg::coord_t sx;
    lsrc_pkg::coord_t sy;
    lsrc_pkg::coord_t ex;
    lsrc_pkg::coord_t ey;
  } res_t;

  lsrc_pkg::item_t           div_r [DIV_STAGES];
  logic [DIV_STAGES-1:0]     dvld_r;
  cmb_t                      cmb_r, cmb_nxt;
  logic                      cvld_r;
  mul_t                      mul_r, mul_nxt;
  logic                      mvld_r;
  res_t                      out_r, out_nxt;
  logic                      ovld_r;
  logic                      en;

  function automatic lsrc_pkg::item_t div_step(input lsrc_pkg::item_t it);
    lsrc_pkg::item_t  o;
    logic [lsrc_pkg::D_W:0] sh;
    o = it;
    for (int i = 0; i < lsrc_pkg::NUM_EDGES; i++) begin
      sh = {it.edges[i].rem, 1'b0};
      if (sh >= {2'b00, it.edges[i].pmag}) begin
        o.edges[i].rem  = lsrc_pkg::D_W'(sh - {2'b00, it.edges[i].pmag});
        o.edges[i].quot = {it.edges[i].quot[lsrc_pkg::FRAC_BITS-2:0], 1'b1};
      end else begin
        o.edges[i].rem  = sh[lsrc_pkg::D_W-1:0];
        o.edges[i].quot = {it.edges[i].quot[lsrc_pkg::FRAC_BITS-2:0], 1'b0};
      end
    end
    return o;
  endfunction

  function automatic lsrc_pkg::coord_t lerp(input lsrc_pkg::coord_t c0,
                                            input logic signed [lsrc_pkg::PROD_W-1:0] pr);
    logic signed [lsrc_pkg::ACC_W-1:0] acc;
    acc = $signed({{(lsrc_pkg::ACC_W-lsrc_pkg::COORD_BITS-lsrc_pkg::FRAC_BITS){1'b0}},
                   c0, {lsrc_pkg::FRAC_BITS{1'b0}}})
        + lsrc_pkg::ACC_W'(pr)
        + $signed(lsrc_pkg::ACC_W'(1) <<< (lsrc_pkg::FRAC_BITS - 1));
    return acc[lsrc_pkg::FRAC_BITS +: lsrc_pkg::COORD_BITS];
  endfunction

  // narrow the entry and exit limits in edge order
  always_comb begin
    lsrc_pkg::item_t               it;
    logic                          ok;
    logic [lsrc_pkg::U_W-1:0]      u1, u2, m;
    logic signed [lsrc_pkg::R_W-1:0] r;
    it = div_r[DIV_STAGES-1];
    ok = !it.rej;
    u1 = '0;
    u2 = lsrc_pkg::U_W'(1) << lsrc_pkg::FRAC_BITS;
    for (int i = 0; i < lsrc_pkg::NUM_EDGES; i++) begin
      if (it.edges[i].big) begin
        m = (lsrc_pkg::U_W'(1) << lsrc_pkg::FRAC_BITS) + lsrc_pkg::U_W'(1);
      end else if (it.edges[i].eq) begin
        m = lsrc_pkg::U_W'(1) << lsrc_pkg::FRAC_BITS;
      end else begin
        m = {1'b0, it.edges[i].quot};
      end
      r = (it.edges[i].qneg ^ it.edges[i].pneg) ? -$signed({1'b0, m}) : $signed({1'b0, m});
      if (ok && !it.edges[i].pzero) begin
        if (it.edges[i].pneg) begin
          if (r > $signed({1'b0, u2})) begin
            ok = 1'b0;
          end else if (r > $signed({1'b0, u1})) begin
            u1 = r[lsrc_pkg::U_W-1:0];
          end
        end else begin
          if (r < $signed({1'b0, u1})) begin
            ok = 1'b0;
          end else if (r < $signed({1'b0, u2})) begin
            u2 = r[lsrc_pkg::U_W-1:0];
          end
        end
      end
    end
    cmb_nxt.x0  = it.x0;
    cmb_nxt.y0  = it.y0;
    cmb_nxt.dx  = it.dx;
    cmb_nxt.dy  = it.dy;
    cmb_nxt.vis = ok && (u1 <= u2);
    cmb_nxt.u1  = u1;
    cmb_nxt.u2  = u2;
  end

  always_comb begin
    mul_nxt.x0  = cmb_r.x0;
    mul_nxt.y0  = cmb_r.y0;
    mul_nxt.dx  = cmb_r.dx;
    mul_nxt.dy  = cmb_r.dy;
    mul_nxt.vis = cmb_r.vis;
    mul_nxt.psx = $signed({1'b0, cmb_r.u1}) * cmb_r.dx;
    mul_nxt.psy = $signed({1'b0, cmb_r.u1}) * cmb_r.dy;
    mul_nxt.pex = $signed({1'b0, cmb_r.u2}) * cmb_r.dx;
    mul_nxt.pey = $signed({1'b0, cmb_r.u2}) * cmb_r.dy;
  end

  always_comb begin
    out_nxt.vis = mul_r.vis;
    if (mul_r.vis) begin
      out_nxt.sx = lerp(mul_r.x0, mul_r.psx);
      out_nxt.sy = lerp(mul_r.y0, mul_r.psy);
      out_nxt.ex = lerp(mul_r.x0, mul_r.pex);
      out_nxt.ey = lerp(mul_r.y0, mul_r.pey);
    end else begin
      out_nxt.sx = mul_r.x0;
      out_nxt.sy = mul_r.y0;
      out_nxt.ex = mul_r.x0 + mul_r.dx[lsrc_pkg::COORD_BITS-1:0];
      out_nxt.ey = mul_r.y0 + mul_r.dy[lsrc_pkg::COORD_BITS-1:0];
    end
  end

  assign en  = !ovld_r || out_ch.ready;
  assign pop = en && !stat.empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dvld_r <= '0;
      cvld_r <= 1'b0;
      mvld_r <= 1'b0;
      ovld_r <= 1'b0;
    end else if (en) begin
      dvld_r <= {dvld_r[DIV_STAGES-2:0], !stat.empty};
      cvld_r <= dvld_r[DIV_STAGES-1];
      mvld_r <= cvld_r;
      ovld_r <= mvld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      div_r[0] <= div_step(fifo_item);
      for (int s = 1; s < DIV_STAGES; s++) begin
        div_r[s] <= div_step(div_r[s-1]);
      end
      cmb_r <= cmb_nxt;
      mul_r <= mul_nxt;
      out_r <= out_nxt;
    end
  end

  assign out_ch.valid           = ovld_r;
  assign out_ch.visible         = out_r.vis;
  assign out_ch.clipped_start_x = out_r.sx;
  assign out_ch.clipped_start_y = out_r.sy;
  assign out_ch.clipped_end_x   = out_r.ex;
  assign out_ch.clipped_end_y   = out_r.ey;

  `LSRC_ASSERT_IMP(a_rem_bound, dvld_r[0] && !div_r[0].edges[0].pzero, div_r[0].edges[0].rem < {1'b0, div_r[0].edges[0].pmag}, "divider remainder not below divisor")
  `LSRC_ASSERT_IMP(a_limits_order, cvld_r && cmb_r.vis, cmb_r.u1 <= cmb_r.u2, "visible segment with crossed limits")
  `LSRC_ASSERT_NEXT(a_out_hold, ovld_r && !out_ch.ready, ovld_r && $stable(out_r), "stalled result changed")

endmodule

### design/line_segment_rect_clipper.sv
// ----------------------------------------------------------------------------
// line_segment_rect_clipper
// clips a line segment against a configured axis-aligned window
// ----------------------------------------------------------------------------
// channel   dir   payload
// in_ch     in    start_x, start_y, end_x, end_y
// out_ch    out   visible, clipped_start_x/y, clipped_end_x/y
// cfg_*     in    register index, write data
//
// one segment per cycle sustained while out_ch.ready holds
// the 16-stage radix-2 divide pipeline gives one quotient bit a stage
// a 2-entry queue lets the classify stage keep taking requests while the
// back end is stalled by out_ch.ready
// synchronous active-low reset; no clearing pass
// ----------------------------------------------------------------------------
module line_segment_rect_clipper (
  input  logic                             clk,
  input  logic                             rst_n,
  lsrc_in_if.sink                          in_ch,
  lsrc_out_if.source                       out_ch,
  input  logic                             cfg_we,
  input  logic [lsrc_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  lsrc_pkg::coord_t                 cfg_wdata
);

  lsrc_pkg::coord_t     min_x_r, min_y_r, max_x_r, max_y_r;
  lsrc_pkg::fifo_stat_t stat;
  logic                 push, pop;
  lsrc_pkg::item_t      push_item, pop_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_x_r <= '0;
      min_y_r <= '0;
      max_x_r <= '1;
      max_y_r <= '1;
    end else if (cfg_we) begin
      case (cfg_idx)
        lsrc_pkg::CFG_MIN_X: min_x_r <= cfg_wdata;
        lsrc_pkg::CFG_MIN_Y: min_y_r <= cfg_wdata;
        lsrc_pkg::CFG_MAX_X: max_x_r <= cfg_wdata;
        lsrc_pkg::CFG_MAX_Y: max_y_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  lsrc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .min_x     (min_x_r),
    .min_y     (min_y_r),
    .max_x     (max_x_r),
    .max_y     (max_y_r),
    .stat      (stat),
    .push      (push),
    .push_item (push_item)
  );

  lsrc_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .stat      (stat)
  );

  lsrc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .fifo_item (pop_item),
    .stat      (stat),
    .pop       (pop),
    .out_ch    (out_ch)
  );

endmodule
